/* hdl/lsq_pkg.sv */
// Shared types, constants and helper functions for the largest-ones-square stream.
// No dependencies; every other file in hdl/ refers to this package by scoped name.
package lsq_pkg;

    // Frame geometry limits
    localparam int MAX_COLS = 1024;
    localparam int MAX_ROWS = 1024;

    // Field widths fixed by the interface
    localparam int SIDE_W = 11;
    localparam int CNT_W  = 11;
    localparam int IDX_W  = 1;

    // Position counter widths, derived from the limits
    localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

    // Width wide enough to compare counts, limits and positions plus one
    localparam int CMP_A = (CNT_W > COL_W + 1) ? CNT_W : COL_W + 1;
    localparam int CMP_W = (CMP_A > ROW_W + 1) ? CMP_A : ROW_W + 1;

    // Register indexes
    localparam logic [IDX_W-1:0] REG_ROW_COUNT = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_COL_COUNT = IDX_W'(1);

    // Count reset value
    localparam logic [CNT_W-1:0] COUNT_RST = CNT_W'(1024);

    // One pixel in flight between the scheduler and the compute stage
    typedef struct packed {
        logic             pixel;
        logic             border;     // first processed row or column
        logic             frame_end;
        logic [COL_W-1:0] col;
    } t_slot;

    // A zero count acts as one, a count above the limit acts as the limit
    function automatic logic [CMP_W-1:0] clamp_count(
        input logic [CNT_W-1:0] v,
        input logic [CMP_W-1:0] top
    );
        logic [CMP_W-1:0] w;
        w = CMP_W'(v);
        if (v == '0) begin
            return CMP_W'(1);
        end else if (w > top) begin
            return top;
        end else begin
            return w;
        end
    endfunction

    function automatic logic [SIDE_W-1:0] min3(
        input logic [SIDE_W-1:0] a,
        input logic [SIDE_W-1:0] b,
        input logic [SIDE_W-1:0] c
    );
        logic [SIDE_W-1:0] m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

endpackage

/* hdl/lsq_line_buf.sv */
// Line buffer holding the square sides of the previous processed row.
// Depends on lsq_pkg. One read and one write per cycle, registered read with bypass.
module lsq_line_buf (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_rd_en,
    input  logic [lsq_pkg::COL_W-1:0]  i_rd_addr,
    input  logic                      i_wr_en,
    input  logic [lsq_pkg::COL_W-1:0]  i_wr_addr,
    input  logic [lsq_pkg::SIDE_W-1:0] i_wr_data,
    output logic [lsq_pkg::SIDE_W-1:0] o_rd_data
);

    logic [lsq_pkg::SIDE_W-1:0] r_mem [lsq_pkg::MAX_COLS];
    logic [lsq_pkg::SIDE_W-1:0] r_rd_q;
    logic [lsq_pkg::SIDE_W-1:0] r_fwd_data;
    logic                       r_fwd;

    // Storage: write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read; held while no new read is issued
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_q     <= r_mem[i_rd_addr];
            r_fwd_data <= i_wr_data;
        end
    end

    // Bypass flag for a read of the entry written in the same cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else if (i_rd_en) begin
            r_fwd <= i_wr_en && (i_wr_addr == i_rd_addr);
        end
    end

    assign o_rd_data = r_fwd ? r_fwd_data : r_rd_q;

    // A colliding read returns the freshly written side
    a_bypass : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rd_en && i_wr_en && (i_wr_addr == i_rd_addr)) |=> (o_rd_data == $past(i_wr_data)))
        else $error("line buffer bypass returned stale data");

endmodule

/* hdl/lsq_sched.sv */
// Configuration registers, position counters and the read-issue stage.
// Depends on lsq_pkg. Issues one line-buffer read per accepted pixel.
module lsq_sched (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [lsq_pkg::IDX_W-1:0]  i_cfg_idx,
    input  logic [lsq_pkg::CNT_W-1:0]  i_cfg_data,
    input  logic                      i_valid,
    input  logic                      i_pixel,
    input  logic                      i_adv,
    output logic                      o_stall,
    output logic                      o_rd_en,
    output logic [lsq_pkg::COL_W-1:0]  o_rd_addr,
    output logic                      o_slot_valid,
    output lsq_pkg::t_slot            o_slot
);

    logic [lsq_pkg::CNT_W-1:0] r_row_count;
    logic [lsq_pkg::CNT_W-1:0] r_col_count;
    logic [lsq_pkg::COL_W-1:0] r_col;
    logic [lsq_pkg::ROW_W-1:0] r_row;
    logic                      r_a_valid;
    lsq_pkg::t_slot            r_slot;

    logic [lsq_pkg::CMP_W-1:0] rows;
    logic [lsq_pkg::CMP_W-1:0] cols;
    logic                      last_col;
    logic                      last_row;
    logic                      accept;

    // Effective frame size
    assign rows = lsq_pkg::clamp_count(r_row_count, lsq_pkg::CMP_W'(lsq_pkg::MAX_ROWS));
    assign cols = lsq_pkg::clamp_count(r_col_count, lsq_pkg::CMP_W'(lsq_pkg::MAX_COLS));

    assign last_col = (lsq_pkg::CMP_W'(r_col) + lsq_pkg::CMP_W'(1)) >= cols;
    assign last_row = (lsq_pkg::CMP_W'(r_row) + lsq_pkg::CMP_W'(1)) >= rows;

    // Slot is free when empty or being taken by the compute stage
    assign o_stall = r_a_valid && !i_adv;
    assign accept  = i_valid && !o_stall;

    assign o_rd_en      = accept;
    assign o_rd_addr    = r_col;
    assign o_slot_valid = r_a_valid;
    assign o_slot       = r_slot;

    // Control state: configuration, counters, slot valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count <= lsq_pkg::COUNT_RST;
            r_col_count <= lsq_pkg::COUNT_RST;
            r_col       <= '0;
            r_row       <= '0;
            r_a_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    lsq_pkg::REG_ROW_COUNT: r_row_count <= i_cfg_data;
                    lsq_pkg::REG_COL_COUNT: r_col_count <= i_cfg_data;
                    default: ;
                endcase
            end
            if (accept) begin
                if (last_col) begin
                    r_col <= '0;
                    r_row <= last_row ? '0 : r_row + lsq_pkg::ROW_W'(1);
                end else begin
                    r_col <= r_col + lsq_pkg::COL_W'(1);
                end
            end
            if (accept) begin
                r_a_valid <= 1'b1;
            end else if (i_adv) begin
                r_a_valid <= 1'b0;
            end
        end
    end

    // Slot payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_slot.pixel     <= i_pixel;
            r_slot.border    <= (r_row == '0) || (r_col == '0);
            r_slot.frame_end <= last_col && last_row;
            r_slot.col       <= r_col;
        end
    end

    // Stall only ever comes from a full slot
    a_stall_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_a_valid)
        else $error("stall raised with an empty slot");

endmodule

/* hdl/lsq_calc.sv */
// Square-side recurrence, running maximum and output register.
// Depends on lsq_pkg. Writes each side back to the line buffer as it is produced.
module lsq_calc (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_slot_valid,
    input  lsq_pkg::t_slot            i_slot,
    input  logic [lsq_pkg::SIDE_W-1:0] i_below,
    input  logic                      i_stall,
    output logic                      o_adv,
    output logic                      o_wr_en,
    output logic [lsq_pkg::COL_W-1:0]  o_wr_addr,
    output logic [lsq_pkg::SIDE_W-1:0] o_wr_data,
    output logic                      o_valid,
    output logic [lsq_pkg::SIDE_W-1:0] o_square_side,
    output logic [lsq_pkg::SIDE_W-1:0] o_largest_side,
    output logic                      o_frame_end
);

    logic [lsq_pkg::SIDE_W-1:0] r_neighbor;
    logic [lsq_pkg::SIDE_W-1:0] r_diag;
    logic [lsq_pkg::SIDE_W-1:0] r_best;
    logic                       r_out_valid;
    logic [lsq_pkg::SIDE_W-1:0] r_square_side;
    logic [lsq_pkg::SIDE_W-1:0] r_largest_side;
    logic                       r_frame_end;

    logic [lsq_pkg::SIDE_W-1:0] side;
    logic [lsq_pkg::SIDE_W-1:0] n_best;
    logic                       fire;

    // Output register frees when empty or taken this cycle
    assign o_adv = !(r_out_valid && i_stall);
    assign fire  = i_slot_valid && o_adv;

    // Side recurrence
    always_comb begin
        priority if (i_slot.border) begin
            side = lsq_pkg::SIDE_W'(i_slot.pixel);
        end else if (!i_slot.pixel) begin
            side = '0;
        end else begin
            side = lsq_pkg::min3(r_diag, r_neighbor, i_below) + lsq_pkg::SIDE_W'(1);
        end
    end

    assign n_best = (side > r_best) ? side : r_best;

    assign o_wr_en   = fire;
    assign o_wr_addr = i_slot.col;
    assign o_wr_data = side;

    // Neighbour, diagonal and running maximum, cleared at frame end; output valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_neighbor  <= '0;
            r_diag      <= '0;
            r_best      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_neighbor <= i_slot.frame_end ? '0 : side;
                r_diag     <= i_slot.frame_end ? '0 : i_below;
                r_best     <= i_slot.frame_end ? '0 : n_best;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Output beat payload
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_square_side  <= side;
            r_largest_side <= n_best;
            r_frame_end    <= i_slot.frame_end;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_square_side  = r_square_side;
    assign o_largest_side = r_largest_side;
    assign o_frame_end    = r_frame_end;

    // Running maximum covers the current side
    a_best_covers : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_largest_side >= r_square_side))
        else $error("largest side below current side");

    // Maximum is cleared once the frame-end pixel has been computed
    a_best_clear : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && i_slot.frame_end) |=> (r_best == '0))
        else $error("running maximum not cleared at frame end");

endmodule

/* hdl/largest_ones_square_stream_top.sv */
// Top level of the largest-ones-square stream: ties scheduler, line buffer and compute.
// Depends on lsq_pkg, lsq_sched, lsq_line_buf and lsq_calc.
//
// Pixels arrive bottom row first, right to left; each beat returns the side of the
// largest all-ones square cornered at that pixel, the frame's running maximum and a
// frame-end flag. One pixel per clock is sustained unless the output stalls; the
// previous-row sides sit in a single line buffer with one read and one write port, read
// when a pixel is accepted and written back as its side is computed. Row and column
// counts are written only while no beat is in flight, a user duty the block does not
// enforce. A change part-way through a frame takes effect on the next pixel, and a
// position at or past the new last column or row counts as the last one. No clearing
// pass is needed after reset, since the first row of every frame never uses the buffer.
module largest_ones_square_stream_top (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [lsq_pkg::IDX_W-1:0]  i_cfg_idx,
    input  logic [lsq_pkg::CNT_W-1:0]  i_cfg_data,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic                      i_pixel,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [lsq_pkg::SIDE_W-1:0] o_square_side,
    output logic [lsq_pkg::SIDE_W-1:0] o_largest_side,
    output logic                      o_frame_end
);

    logic                       rd_en;
    logic [lsq_pkg::COL_W-1:0]  rd_addr;
    logic                       slot_valid;
    lsq_pkg::t_slot             slot;
    logic                       adv;
    logic                       wr_en;
    logic [lsq_pkg::COL_W-1:0]  wr_addr;
    logic [lsq_pkg::SIDE_W-1:0] wr_data;
    logic [lsq_pkg::SIDE_W-1:0] below;

    lsq_sched u_sched (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .i_pixel      (i_pixel),
        .i_adv        (adv),
        .o_stall      (o_stall),
        .o_rd_en      (rd_en),
        .o_rd_addr    (rd_addr),
        .o_slot_valid (slot_valid),
        .o_slot       (slot)
    );

    lsq_line_buf u_line_buf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .o_rd_data (below)
    );

    lsq_calc u_calc (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_slot_valid   (slot_valid),
        .i_slot         (slot),
        .i_below        (below),
        .i_stall        (i_stall),
        .o_adv          (adv),
        .o_wr_en        (wr_en),
        .o_wr_addr      (wr_addr),
        .o_wr_data      (wr_data),
        .o_valid        (o_valid),
        .o_square_side  (o_square_side),
        .o_largest_side (o_largest_side),
        .o_frame_end    (o_frame_end)
    );

endmodule

/* tb/sv/tb_largest_ones_square_stream_top.sv */
// Self-checking testbench for largest_ones_square_stream_top: random and directed pixel
// frames, with a scoreboard class that predicts every result beat. Needs lsq_pkg and
// the RTL under hdl/.

// One result beat as the block should present it
typedef struct packed {
    logic [lsq_pkg::SIDE_W-1:0] square_side;
    logic [lsq_pkg::SIDE_W-1:0] largest_side;
    logic                       frame_end;
} t_side_beat;

// Square-side predictor with its own copy of the counts and line state
class square_side_board;
    logic [lsq_pkg::CNT_W-1:0]  row_count = lsq_pkg::COUNT_RST;
    logic [lsq_pkg::CNT_W-1:0]  col_count = lsq_pkg::COUNT_RST;
    logic [lsq_pkg::SIDE_W-1:0] below_row [lsq_pkg::MAX_COLS];
    logic [lsq_pkg::SIDE_W-1:0] right_side = '0;
    logic [lsq_pkg::SIDE_W-1:0] diag_side  = '0;
    logic [lsq_pkg::SIDE_W-1:0] best       = '0;
    logic [lsq_pkg::COL_W-1:0]  col_pos    = '0;
    logic [lsq_pkg::ROW_W-1:0]  row_pos    = '0;
    t_side_beat                 pending_sides [$];
    int unsigned                bad_beats  = 0;

    // zero acts as one, anything past the limit acts as the limit
    function int unsigned limit_count(logic [lsq_pkg::CNT_W-1:0] v, int unsigned top);
        if (v == '0) return 1;
        if (32'(v) > top) return top;
        return 32'(v);
    endfunction

    function void write_count(logic [lsq_pkg::IDX_W-1:0] idx,
                              logic [lsq_pkg::CNT_W-1:0] value);
        if (idx == lsq_pkg::REG_ROW_COUNT) row_count = value;
        else if (idx == lsq_pkg::REG_COL_COUNT) col_count = value;
    endfunction

    // predict the beat for one accepted pixel and advance the position
    function void note_pixel(logic pix);
        int unsigned rows, cols, below, side, least;
        bit          last_col, last_row;
        t_side_beat  beat;
        rows  = limit_count(row_count, lsq_pkg::MAX_ROWS);
        cols  = limit_count(col_count, lsq_pkg::MAX_COLS);
        below = 32'(below_row[col_pos]);
        if (row_pos == 0 || col_pos == 0) begin
            side = 32'(pix);
        end else if (!pix) begin
            side = 0;
        end else begin
            least = 32'(diag_side);
            if (32'(right_side) < least) least = 32'(right_side);
            if (below < least) least = below;
            side = (least + 1) & ((1 << lsq_pkg::SIDE_W) - 1);
        end
        diag_side          = lsq_pkg::SIDE_W'(below);
        below_row[col_pos] = lsq_pkg::SIDE_W'(side);
        right_side         = lsq_pkg::SIDE_W'(side);
        if (side > 32'(best)) best = lsq_pkg::SIDE_W'(side);

        last_col = (32'(col_pos) + 32'd1 >= cols);
        last_row = (32'(row_pos) + 32'd1 >= rows);
        beat.square_side  = lsq_pkg::SIDE_W'(side);
        beat.largest_side = best;
        beat.frame_end    = last_col && last_row;
        pending_sides.push_back(beat);

        if (last_col && last_row) begin
            col_pos    = '0;
            row_pos    = '0;
            best       = '0;
            right_side = '0;
            diag_side  = '0;
        end else if (last_col) begin
            col_pos = '0;
            row_pos = row_pos + lsq_pkg::ROW_W'(1);
        end else begin
            col_pos = col_pos + lsq_pkg::COL_W'(1);
        end
    endfunction

    // compare an accepted result beat against the oldest prediction
    function void check_beat(t_side_beat got);
        t_side_beat want;
        if (pending_sides.size() == 0) begin
            bad_beats++;
            if (bad_beats <= 10)
                $display("unexpected beat: side %0d largest %0d end %0b",
                         got.square_side, got.largest_side, got.frame_end);
            return;
        end
        want = pending_sides.pop_front();
        if (got.square_side !== want.square_side || got.largest_side !== want.largest_side
                || got.frame_end !== want.frame_end) begin
            bad_beats++;
            if (bad_beats <= 10)
                $display("beat mismatch: expected side %0d largest %0d end %0b, got %0d %0d %0b",
                         want.square_side, want.largest_side, want.frame_end,
                         got.square_side, got.largest_side, got.frame_end);
        end
    endfunction
endclass

module tb_largest_ones_square_stream_top;

    localparam int SETTLE_CYCLES = 4;
    localparam int HOLD_CYCLES   = 300;
    localparam int QUIET_LIMIT   = 4000;
    localparam int PHASE_ITEMS   = 140;

    logic                         i_clk      = 1'b0;
    logic                         i_rst_n    = 1'b0;
    logic                         i_cfg_we   = 1'b0;
    logic [lsq_pkg::IDX_W-1:0]    i_cfg_idx  = '0;
    logic [lsq_pkg::CNT_W-1:0]    i_cfg_data = '0;
    logic                         i_valid    = 1'b0;
    logic                         o_stall;
    logic                         i_pixel    = 1'b0;
    logic                         o_valid;
    logic                         i_stall    = 1'b0;
    logic [lsq_pkg::SIDE_W-1:0]   o_square_side;
    logic [lsq_pkg::SIDE_W-1:0]   o_largest_side;
    logic                         o_frame_end;

    square_side_board board = new();

    int unsigned send_idle_pct = 0;
    int unsigned stall_pct     = 0;
    bit          hold_request  = 1'b0;
    int unsigned hold_left     = 0;
    int unsigned quiet_cycles  = 0;

    largest_ones_square_stream_top uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_pixel        (i_pixel),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_square_side  (o_square_side),
        .o_largest_side (o_largest_side),
        .o_frame_end    (o_frame_end)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // offer one pixel beat, with a random gap first, and wait for it to be taken
    task automatic send_pixel(input logic pix);
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_valid <= 1'b1;
        i_pixel <= pix;
        do @(posedge i_clk); while (o_stall);
        board.note_pixel(pix);
    endtask

    task automatic send_run(input int unsigned n, input int unsigned ones_pct);
        for (int unsigned k = 0; k < n; k++) send_pixel($urandom_range(99) < ones_pct);
    endtask

    // counts change only with the block drained
    task automatic set_count(input logic [lsq_pkg::IDX_W-1:0] idx,
                             input logic [lsq_pkg::CNT_W-1:0] value);
        i_valid <= 1'b0;
        while (board.pending_sides.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        board.write_count(idx, value);
    endtask

    function automatic logic [lsq_pkg::CNT_W-1:0] pick_count(input int unsigned top);
        if ($urandom_range(9) == 0) return '0;
        return lsq_pkg::CNT_W'($urandom_range(top, 1));
    endfunction

    // result side: check accepted beats, then choose the next stall
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            board.check_beat('{o_square_side, o_largest_side, o_frame_end});
        if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left != 0) begin
            i_stall <= 1'b1;
            hold_left--;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // watchdog on cycles with no beat moving on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        int unsigned phase_items, n, which;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero counts act as one: single-pixel frames
        set_count(lsq_pkg::REG_ROW_COUNT, '0);
        set_count(lsq_pkg::REG_COL_COUNT, '0);
        send_pixel(1'b0);
        send_pixel(1'b1);

        // 3x3 of ones grows a square of three
        set_count(lsq_pkg::REG_ROW_COUNT, 11'd3);
        set_count(lsq_pkg::REG_COL_COUNT, 11'd3);
        send_run(9, 100);

        // width shrinks under the column position, then height under the row position
        set_count(lsq_pkg::REG_COL_COUNT, 11'd4);
        send_pixel(1'b1);
        send_pixel(1'b1);
        send_pixel(1'b0);
        send_pixel(1'b1);
        send_pixel(1'b1);
        send_pixel(1'b1);
        set_count(lsq_pkg::REG_COL_COUNT, 11'd2);
        send_pixel(1'b1);
        set_count(lsq_pkg::REG_ROW_COUNT, 11'd1);
        send_pixel(1'b1);
        send_pixel(1'b1);

        // width grows part-way through a frame
        set_count(lsq_pkg::REG_ROW_COUNT, 11'd2);
        set_count(lsq_pkg::REG_COL_COUNT, 11'd1);
        send_pixel(1'b1);
        set_count(lsq_pkg::REG_COL_COUNT, 11'd3);
        send_run(5, 100);

        // random part, one idling pattern per phase
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 81; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 81; end
                default: begin send_idle_pct = 16; stall_pct = 16; end
            endcase

            // one fixed run in each of the first three phases; the first writes every column the small frames use
            case (ph)
                0: begin
                    set_count(lsq_pkg::REG_ROW_COUNT, 11'd1);
                    set_count(lsq_pkg::REG_COL_COUNT, 11'd12);
                    send_run(12, 90);
                end
                1: begin
                    set_count(lsq_pkg::REG_ROW_COUNT, 11'd2047);
                    set_count(lsq_pkg::REG_COL_COUNT, 11'd12);
                    send_run(48, 95);
                end
                2: begin
                    set_count(lsq_pkg::REG_ROW_COUNT, 11'd4);
                    set_count(lsq_pkg::REG_COL_COUNT, 11'd2047);
                    send_run(40, 95);
                end
                default: ;
            endcase

            // small frames, counts often changed part-way through a frame
            phase_items = 0;
            while (phase_items < PHASE_ITEMS) begin
                which = $urandom_range(2);
                if (which != 1) set_count(lsq_pkg::REG_ROW_COUNT, pick_count(8));
                if (which != 0) set_count(lsq_pkg::REG_COL_COUNT, pick_count(12));
                n = $urandom_range(40, 4);
                if (ph == 0 && phase_items == 0) begin
                    // long receiver hold-off while pixels keep coming
                    hold_request = 1'b1;
                    n = 60;
                end
                case ($urandom_range(2))
                    0: send_run(n, 50);
                    1: send_run(n, 85);
                    default: send_run(n, 100);
                endcase
                phase_items += n;
            end
        end

        i_valid <= 1'b0;
        while (board.pending_sides.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (board.bad_beats == 0 && board.pending_sides.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
